FILE: rtl/urhr_pkg.sv
// Shared constants and codes for the undo/redo history ring.
package urhr_pkg;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned ENTRY_WIDTH = 32;
  localparam int unsigned PTR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [PTR_W-1:0]       ptr_t;
  typedef logic [ENTRY_WIDTH-1:0] entry_t;

  typedef enum logic [2:0] {
    MODE_APPEND_NOTE  = 3'd0,
    MODE_APPEND_QUIET = 3'd1,
    MODE_UNDO         = 3'd2,
    MODE_REDO         = 3'd3,
    MODE_CLEAR        = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_NOTICE = 2'd1,
    EV_UNDO   = 2'd2,
    EV_REDO   = 2'd3
  } event_t;

  // Per-beat result info carried alongside the store read.
  typedef struct packed {
    event_t ev;
    logic   use_rd;
    logic   undo_en;
    logic   redo_en;
  } res_meta_t;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == ptr_t'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic ptr_t ring_prev(input ptr_t p);
    ring_prev = (p == '0) ? ptr_t'(DEPTH - 1) : p - ptr_t'(1);
  endfunction

endpackage

FILE: rtl/urhr_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module urhr_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/undo_redo_history_ring_core.sv
// Top level of the undo/redo history ring: cursor control, store and result stage.
//
// Input channel (in_valid/in_ready): one command beat carries in_mode and
// in_entry_data. Modes: append with notice, append silently, undo, redo, clear.
// Result channel (out_valid/out_ready): exactly one result beat per command,
// in command order, with out_event_res, out_entry_out, out_undo_enable and
// out_redo_enable.
// Path: a result passes the synchronous store read, registered in the RAM
// with its info in the pending stage, and then the output register.
// Throughput: one command per cycle while in_ready is high. Cursor, oldest
// and newest bounds live in registers updated at acceptance; the entry store
// is a RAM with one write and one read port, and an append writes at the
// edge the beat is accepted, so a following undo or redo reads the fresh word.
// Stall: a pending stage and the output register let the input side keep
// accepting while out_ready is low until both are full; after that in_ready
// drops and nothing is lost or repeated.
// Reset: the ring is empty, all positions zero, no result pending. The store
// is not cleared; entries beyond the bounds are never returned.
module undo_redo_history_ring_core
  import urhr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [31:0] in_entry_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [31:0] out_entry_out,
  output logic        out_undo_enable,
  output logic        out_redo_enable
);

  ptr_t cursor_r, cursor_nxt;
  ptr_t oldest_r, oldest_nxt;
  ptr_t newest_r, newest_nxt;
  logic empty_r, empty_nxt;

  logic      pend_r, pend_nxt;
  res_meta_t pend_meta_r, pend_meta_nxt;

  logic        ov_r, ov_nxt;
  res_meta_t   ov_meta_r;
  logic [31:0] ov_data_r;

  logic   accept, adv;
  logic   wr_en, rd_en;
  ptr_t   wr_addr, rd_addr;
  entry_t rd_data;
  ptr_t   cur_step;

  assign adv      = !ov_r || out_ready;
  assign in_ready = !pend_r || adv;
  assign accept   = in_valid && in_ready;

  // Command decode: next bounds, store access and result info.
  always_comb begin
    cursor_nxt    = cursor_r;
    oldest_nxt    = oldest_r;
    newest_nxt    = newest_r;
    empty_nxt     = empty_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    cur_step      = ring_next(cursor_r);
    wr_addr       = cur_step;
    rd_addr       = cursor_r;
    pend_meta_nxt = '{ev: EV_NONE, use_rd: 1'b0, undo_en: 1'b0, redo_en: 1'b0};
    case (in_mode)
      MODE_APPEND_NOTE, MODE_APPEND_QUIET: begin
        if (empty_r) begin
          cursor_nxt = '0;
          oldest_nxt = '0;
        end else begin
          cursor_nxt = cur_step;
          if (oldest_r == cur_step) begin
            oldest_nxt = ring_next(oldest_r);
          end
        end
        empty_nxt  = 1'b0;
        newest_nxt = cursor_nxt;
        wr_en      = accept;
        wr_addr    = cursor_nxt;
        pend_meta_nxt.ev = (in_mode == MODE_APPEND_NOTE) ? EV_NOTICE : EV_NONE;
      end
      MODE_UNDO: begin
        if (!empty_r) begin
          rd_en                = accept;
          rd_addr              = cursor_r;
          pend_meta_nxt.ev     = EV_UNDO;
          pend_meta_nxt.use_rd = 1'b1;
          if (cursor_r != oldest_r) begin
            cursor_nxt = ring_prev(cursor_r);
          end
        end
      end
      MODE_REDO: begin
        if (!empty_r && cursor_r != newest_r) begin
          cursor_nxt           = cur_step;
          rd_en                = accept;
          rd_addr              = cur_step;
          pend_meta_nxt.ev     = EV_REDO;
          pend_meta_nxt.use_rd = 1'b1;
        end
      end
      MODE_CLEAR: begin
        cursor_nxt = '0;
        oldest_nxt = '0;
        newest_nxt = '0;
        empty_nxt  = 1'b1;
      end
      default: begin
      end
    endcase
    if (in_mode == MODE_APPEND_NOTE || in_mode == MODE_APPEND_QUIET) begin
      pend_meta_nxt.undo_en = 1'b1;
      pend_meta_nxt.redo_en = 1'b0;
    end else if (!empty_nxt) begin
      pend_meta_nxt.undo_en = (cursor_nxt != oldest_nxt);
      pend_meta_nxt.redo_en = (cursor_nxt != newest_nxt);
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    ov_nxt   = ov_r;
    if (adv) begin
      ov_nxt   = pend_r;
      pend_nxt = 1'b0;
    end
    if (accept) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      oldest_r <= '0;
      newest_r <= '0;
      empty_r  <= 1'b1;
      pend_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (accept) begin
        cursor_r <= cursor_nxt;
        oldest_r <= oldest_nxt;
        newest_r <= newest_nxt;
        empty_r  <= empty_nxt;
      end
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Payload registers; store read data is held in the RAM until the next read.
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_meta_r <= pend_meta_nxt;
    end
    if (adv && pend_r) begin
      ov_meta_r <= pend_meta_r;
      ov_data_r <= pend_meta_r.use_rd ? 32'(rd_data) : 32'd0;
    end
  end

  urhr_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ENTRY_WIDTH),
    .AW    (PTR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_entry_data[ENTRY_WIDTH-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid       = ov_r;
  assign out_event_res   = ov_meta_r.ev;
  assign out_entry_out   = ov_data_r;
  assign out_undo_enable = ov_meta_r.undo_en;
  assign out_redo_enable = ov_meta_r.redo_en;

endmodule
